[sv/afpf_pkg.sv]
`timescale 1ns / 1ps
// afpf_pkg: shared types and constants of the accelerometer frame parser and filter
// no dependencies; imported by the front, queue, back and top modules

package afpf_pkg;

    // frame framing and type codes
    localparam logic [7:0] HEADER_BYTE = 8'h55;
    localparam logic [7:0] ACCEL_TYPE  = 8'h51;

    // filter coefficients in Q14: alpha 0.8 and 1 - alpha
    localparam logic signed [15:0] ALPHA_Q14     = 16'sd13107;
    localparam logic signed [15:0] ONE_MINUS_Q14 = 16'sd3277;
    localparam int unsigned        FRAC_SHIFT    = 14;

    // field widths
    localparam int unsigned SAMPLE_W = 16;
    localparam int unsigned GRAV_W   = 26;
    localparam int unsigned LIN_W    = 27;
    localparam int unsigned THR_W    = 15;
    localparam int unsigned AXES     = 3;

    // queue between parser and filter
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

    // configuration register indexes
    typedef enum logic [1:0] {
        REG_MIN_ACC_X = 2'd0,
        REG_MIN_ACC_Y = 2'd1,
        REG_MIN_ACC_Z = 2'd2
    } cfg_reg_t;

    localparam logic [THR_W-1:0] MIN_ACC_RESET = 15'd205;

    // one parsed byte, as handed from parser to filter
    typedef struct packed {
        logic                       frame_ok;
        logic                       accel;
        logic signed [SAMPLE_W-1:0] sample_x;
        logic signed [SAMPLE_W-1:0] sample_y;
        logic signed [SAMPLE_W-1:0] sample_z;
    } cmd_t;

endpackage

[sv/afpf_front.sv]
`timescale 1ns / 1ps
// afpf_front: byte parser, header hunt, running checksum and frame byte store
// depends on afpf_pkg

module afpf_front #(
    parameter int unsigned FRAME_LEN = 11
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               accept,
    input  logic [7:0]         rx_byte,
    output afpf_pkg::cmd_t     cmd
);
    import afpf_pkg::*;

    localparam logic [3:0] LAST_POS = 4'(FRAME_LEN - 1);

    logic [3:0] pos_reg, pos_next;
    logic [7:0] sum_reg, sum_next;
    logic [7:0] store_reg [1:7];
    logic [7:0] byte_at [1:7];
    logic       hunting, storing, closing, good;

    // classify the incoming byte
    always_comb begin
        hunting = (pos_reg == 4'd0) && (rx_byte != HEADER_BYTE);
        storing = !hunting && (pos_reg < LAST_POS);
        closing = !hunting && !storing;
        good    = closing && (sum_reg == rx_byte);
    end

    // bytes past the frame end are never written and read as zero
    always_comb begin
        for (int k = 1; k <= 7; k++) begin
            byte_at[k] = (k < FRAME_LEN - 1) ? store_reg[k] : 8'd0;
        end
    end

    // command for the filter, one per byte
    always_comb begin
        cmd.frame_ok = good;
        cmd.accel    = good && (byte_at[1] == ACCEL_TYPE);
        cmd.sample_x = $signed({byte_at[3], byte_at[2]});
        cmd.sample_y = $signed({byte_at[5], byte_at[4]});
        cmd.sample_z = $signed({byte_at[7], byte_at[6]});
    end

    // parser state update
    always_comb begin
        pos_next = pos_reg;
        sum_next = sum_reg;
        if (storing) begin
            pos_next = pos_reg + 4'd1;
            sum_next = sum_reg + rx_byte;
        end else if (closing) begin
            pos_next = 4'd0;
            sum_next = 8'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= 4'd0;
            sum_reg <= 8'd0;
        end else if (accept) begin
            pos_reg <= pos_next;
            sum_reg <= sum_next;
        end
    end

    // frame byte store, payload only
    always_ff @(posedge aclk) begin
        for (int k = 1; k <= 7; k++) begin
            if (accept && storing && (pos_reg == 4'(k))) begin
                store_reg[k] <= rx_byte;
            end
        end
    end

endmodule

[sv/afpf_queue.sv]
`timescale 1ns / 1ps
// afpf_queue: short register queue between the parser and the filter pipeline
// depends on afpf_pkg

module afpf_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  afpf_pkg::cmd_t  push_data,
    output logic            full,
    input  logic            pop,
    output afpf_pkg::cmd_t  pop_data,
    output logic            empty
);
    import afpf_pkg::*;

    cmd_t              mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QPTR_W:0]   count_reg, count_next;

    assign full     = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = mem_reg[rd_ptr_reg];

    // occupancy
    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    // entry storage
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

[sv/afpf_back.sv]
`timescale 1ns / 1ps
// afpf_back: three-stage gravity and linear-acceleration filter with result register
// depends on afpf_pkg; fed by afpf_queue

module afpf_back (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_we,
    input  logic [1:0]                         cfg_index,
    input  logic [afpf_pkg::THR_W-1:0]         cfg_wdata,
    input  logic                               q_empty,
    input  afpf_pkg::cmd_t                     q_data,
    output logic                               q_pop,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic                               m_frame_ok,
    output logic                               m_accel_frame,
    output logic signed [afpf_pkg::GRAV_W-1:0] m_gravity_x,
    output logic signed [afpf_pkg::GRAV_W-1:0] m_gravity_y,
    output logic signed [afpf_pkg::GRAV_W-1:0] m_gravity_z,
    output logic signed [afpf_pkg::LIN_W-1:0]  m_lin_acc_x,
    output logic signed [afpf_pkg::LIN_W-1:0]  m_lin_acc_y,
    output logic signed [afpf_pkg::LIN_W-1:0]  m_lin_acc_z
);
    import afpf_pkg::*;

    localparam int unsigned P1_W = 42;
    localparam int unsigned P2_W = 43;

    logic                     advance;
    logic [THR_W-1:0]         min_acc_reg [AXES];
    logic signed [GRAV_W-1:0] grav_reg [AXES];
    logic signed [LIN_W-1:0]  lin_reg  [AXES];

    logic                     a_valid_reg, b_valid_reg, out_valid_reg;
    logic                     a_ok_reg, a_accel_reg, b_ok_reg, b_accel_reg;
    logic                     out_ok_reg, out_accel_reg;
    logic signed [GRAV_W-1:0] q_val [AXES];
    logic signed [GRAV_W-1:0] a_q_reg [AXES];
    logic signed [P1_W-1:0]   p1_next [AXES];
    logic signed [P1_W-1:0]   a_p1_reg [AXES];
    logic signed [GRAV_W-1:0] g_next [AXES];
    logic signed [LIN_W-1:0]  diff [AXES];
    logic signed [P2_W-1:0]   p2_next [AXES];
    logic signed [P2_W-1:0]   b_p2_reg [AXES];
    logic signed [GRAV_W-1:0] b_g_reg [AXES];
    logic signed [LIN_W-1:0]  lin_raw [AXES];
    logic signed [LIN_W-1:0]  lin_next [AXES];
    logic signed [LIN_W-1:0]  thr [AXES];

    // whole pipeline moves when the result register is free or being taken
    assign advance = !out_valid_reg || m_ready;
    assign q_pop   = advance && !q_empty;

    // threshold registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < AXES; i++) begin
                min_acc_reg[i] <= MIN_ACC_RESET;
            end
        end else if (cfg_we) begin
            case (cfg_index)
                REG_MIN_ACC_X: min_acc_reg[0] <= cfg_wdata;
                REG_MIN_ACC_Y: min_acc_reg[1] <= cfg_wdata;
                REG_MIN_ACC_Z: min_acc_reg[2] <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // stage a: samples to Q.10, first weighted sum against current gravity
    always_comb begin
        q_val[0] = $signed({q_data.sample_x, 10'd0});
        q_val[1] = $signed({q_data.sample_y, 10'd0});
        q_val[2] = $signed({q_data.sample_z, 10'd0});
        for (int i = 0; i < AXES; i++) begin
            p1_next[i] = P1_W'(grav_reg[i]) * P1_W'(ALPHA_Q14)
                       + P1_W'(q_val[i]) * P1_W'(ONE_MINUS_Q14);
        end
    end

    // stage b: new gravity, second weighted sum against current linear value
    always_comb begin
        for (int i = 0; i < AXES; i++) begin
            g_next[i]  = GRAV_W'(a_p1_reg[i] >>> FRAC_SHIFT);
            diff[i]    = LIN_W'(a_q_reg[i]) - LIN_W'(g_next[i]);
            p2_next[i] = P2_W'(lin_reg[i]) * P2_W'(ALPHA_Q14)
                       + P2_W'(diff[i]) * P2_W'(ONE_MINUS_Q14);
        end
    end

    // result stage: floor shift and threshold, negatives fall below it too
    always_comb begin
        for (int i = 0; i < AXES; i++) begin
            lin_raw[i]  = LIN_W'(b_p2_reg[i] >>> FRAC_SHIFT);
            thr[i]      = $signed({2'b00, min_acc_reg[i], 10'd0});
            lin_next[i] = (lin_raw[i] < thr[i]) ? '0 : lin_raw[i];
        end
    end

    // pipeline control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            a_valid_reg   <= !q_empty;
            b_valid_reg   <= a_valid_reg;
            out_valid_reg <= b_valid_reg;
        end
    end

    // pipeline payload
    always_ff @(posedge aclk) begin
        if (advance) begin
            a_ok_reg      <= q_data.frame_ok;
            a_accel_reg   <= q_data.accel;
            b_ok_reg      <= a_ok_reg;
            b_accel_reg   <= a_accel_reg;
            out_ok_reg    <= b_ok_reg;
            out_accel_reg <= b_accel_reg;
            for (int i = 0; i < AXES; i++) begin
                a_q_reg[i]  <= q_val[i];
                a_p1_reg[i] <= p1_next[i];
                b_g_reg[i]  <= g_next[i];
                b_p2_reg[i] <= p2_next[i];
            end
        end
    end

    // filter state, updated as an accel frame enters the result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < AXES; i++) begin
                grav_reg[i] <= '0;
                lin_reg[i]  <= '0;
            end
        end else if (advance && b_valid_reg && b_accel_reg) begin
            for (int i = 0; i < AXES; i++) begin
                grav_reg[i] <= b_g_reg[i];
                lin_reg[i]  <= lin_next[i];
            end
        end
    end

    // result port: state only changes on a transfer into the result register
    assign m_valid       = out_valid_reg;
    assign m_frame_ok    = out_ok_reg;
    assign m_accel_frame = out_accel_reg;
    assign m_gravity_x   = grav_reg[0];
    assign m_gravity_y   = grav_reg[1];
    assign m_gravity_z   = grav_reg[2];
    assign m_lin_acc_x   = lin_reg[0];
    assign m_lin_acc_y   = lin_reg[1];
    assign m_lin_acc_z   = lin_reg[2];

endmodule

[sv/accel_frame_parse_filter_top.sv]
`timescale 1ns / 1ps
// accel_frame_parse_filter_top: serial frame parser with gravity and linear-accel filters
// Input channel s_*: one received byte per transfer. Each byte gives exactly one result
// on m_*: frame_ok and accel_frame for that byte, plus the current gravity and linear
// acceleration estimates (Q.10) after that byte.
// Frames start at a 0x55 header, are FRAME_LEN bytes long and end in an 8-bit checksum;
// a good frame of type 0x51 updates the three per-axis filters.
// Thresholds min_acc_x/y/z are written through cfg_we/cfg_index/cfg_wdata by the user,
// only while idle, which the block itself does not enforce. Throughput: one byte per
// cycle while m_ready is high, the parser taking a byte each cycle and the filter
// pipeline moving one item per cycle. A byte passes the queue, stage a, stage b and the
// result register to reach m_*, and waits behind any earlier items in the queue.
// When m_ready is low the filter pipeline holds and the 4-entry queue keeps taking
// bytes until it fills, then s_ready drops.
// Reset (aresetn low, synchronous): parser hunts for a header, checksum and filters are
// zero, thresholds return to 205, queue and pipeline empty.
// depends on afpf_pkg, afpf_front, afpf_queue, afpf_back

module accel_frame_parse_filter_top #(
    parameter int unsigned FRAME_LEN = 11
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_we,
    input  logic [1:0]                         cfg_index,
    input  logic [afpf_pkg::THR_W-1:0]         cfg_wdata,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [7:0]                         s_rx_byte,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic                               m_frame_ok,
    output logic                               m_accel_frame,
    output logic signed [afpf_pkg::GRAV_W-1:0] m_gravity_x,
    output logic signed [afpf_pkg::GRAV_W-1:0] m_gravity_y,
    output logic signed [afpf_pkg::GRAV_W-1:0] m_gravity_z,
    output logic signed [afpf_pkg::LIN_W-1:0]  m_lin_acc_x,
    output logic signed [afpf_pkg::LIN_W-1:0]  m_lin_acc_y,
    output logic signed [afpf_pkg::LIN_W-1:0]  m_lin_acc_z
);
    import afpf_pkg::*;

    logic q_full, q_empty, q_pop, in_xfer;
    cmd_t front_cmd, q_data;

    // input transfer whenever the queue has room
    assign s_ready = !q_full;
    assign in_xfer = s_valid && s_ready;

    afpf_front #(
        .FRAME_LEN (FRAME_LEN)
    ) u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .accept  (in_xfer),
        .rx_byte (s_rx_byte),
        .cmd     (front_cmd)
    );

    afpf_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (in_xfer),
        .push_data (front_cmd),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_data),
        .empty     (q_empty)
    );

    afpf_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .q_empty       (q_empty),
        .q_data        (q_data),
        .q_pop         (q_pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_frame_ok    (m_frame_ok),
        .m_accel_frame (m_accel_frame),
        .m_gravity_x   (m_gravity_x),
        .m_gravity_y   (m_gravity_y),
        .m_gravity_z   (m_gravity_z),
        .m_lin_acc_x   (m_lin_acc_x),
        .m_lin_acc_y   (m_lin_acc_y),
        .m_lin_acc_z   (m_lin_acc_z)
    );

endmodule
